/* sv/ntr_pkg.sv */
// shared types, character codes and digit decode for the number token recogniser
package ntr_pkg;

    // number format chosen by the first character of a token
    typedef enum logic [1:0] {
        MODE_SIGNED   = 2'd0,
        MODE_NEGATIVE = 2'd1,
        MODE_UNSIGNED = 2'd2,
        MODE_HEX      = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_NUMBER     = 2'd0,
        ST_NOT_NUMBER = 2'd1,
        ST_OVERFLOW   = 2'd2
    } status_t;

    // per-token progress flags
    typedef struct packed {
        logic seen_digit;
        logic bad_digit;
        logic overflow;
    } ntr_flags_t;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LO_A   = 8'h61;
    localparam logic [7:0] CHAR_LO_Z   = 8'h7A;

    localparam int unsigned DIGIT_W = 6;
    localparam logic [DIGIT_W-1:0] NOT_A_DIGIT = 6'd63;
    localparam logic [DIGIT_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [DIGIT_W-1:0] BASE_HEX    = 6'd16;

    // digit worth of a character, 0..35, or NOT_A_DIGIT
    function automatic logic [DIGIT_W-1:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'(NOT_A_DIGIT);
        if (c inside {[CHAR_ZERO:CHAR_NINE]})
        begin
            d = c - CHAR_ZERO;
        end
        else if (c inside {[CHAR_LO_A:CHAR_LO_Z]})
        begin
            d = c - CHAR_LO_A + 8'd10;
        end
        else if (c inside {[CHAR_UP_A:CHAR_UP_Z]})
        begin
            d = c - CHAR_UP_A + 8'd10;
        end
        return d[DIGIT_W-1:0];
    endfunction

endpackage

/* sv/number_token_recogniser.sv */
// number token recogniser: parses ascii integer tokens one character per beat
//
// Input channel (in_valid/in_ready) carries one token character per beat in
// token_char, with last_char high on the final character of a token. A token
// starting with '$' is hex, '-' negative decimal, '+' unsigned decimal, and
// anything else signed decimal. Output channel (out_valid/out_ready) carries one
// beat per token: status (0 number, 1 not a number, 2 overflow) and value, the
// low 32 bits of the two's complement result, zero unless status is 0.
// Throughput is one character per cycle unless a last character waits on a
// busy result register; the character register feeds the combinational digit
// accumulate (one constant multiply, add and carry check) that writes the
// parse state and the result register, which drives out_valid.
// When the receiver stalls, the result register holds; one more last character
// can wait in the character register, and non-last characters keep flowing
// until a second completed token needs the result register.
// Reset clears all state; the next character opens a new token.
module number_token_recogniser
    import ntr_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  token_char,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] value
);

    localparam int OUT_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

    logic                   s1_valid_reg;
    logic [7:0]             s1_char_reg;
    logic                   s1_last_reg;
    logic                   at_start_reg;
    mode_t                  mode_reg;
    logic [VALUE_WIDTH-1:0] acc_reg;
    ntr_flags_t             flags_reg;
    logic                   out_valid_reg;
    status_t                status_reg;
    logic [31:0]            value_reg;

    mode_t                  mode_next;
    logic [VALUE_WIDTH-1:0] acc_next;
    ntr_flags_t             flags_next;
    status_t                status_next;
    logic [31:0]            value_next;
    logic [VALUE_WIDTH-1:0] result_w;
    logic [OUT_W-1:0]       result_ext;
    logic                   out_free;
    logic                   s1_consume;

    // handshake: a last character needs a free result register
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_consume = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready   = !s1_valid_reg || s1_consume;

    // character register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_char_reg  <= '0;
            s1_last_reg  <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
            s1_char_reg  <= token_char;
            s1_last_reg  <= last_char;
        end
    end

    // per-character parse step
    ntr_char_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .token_char(s1_char_reg),
        .at_start  (at_start_reg),
        .mode_in   (mode_reg),
        .acc_in    (acc_reg),
        .flags_in  (flags_reg),
        .mode_out  (mode_next),
        .acc_out   (acc_next),
        .flags_out (flags_next)
    );

    // final status and value at the end of a token
    always_comb
    begin
        status_next = ST_NUMBER;
        result_w    = '0;
        if (flags_next.overflow)
        begin
            status_next = ST_OVERFLOW;
        end
        else if (flags_next.bad_digit || !flags_next.seen_digit)
        begin
            status_next = ST_NOT_NUMBER;
        end
        else
        begin
            case (mode_next)
                MODE_SIGNED:
                begin
                    if (acc_next[VALUE_WIDTH-1])
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        result_w = acc_next;
                    end
                end
                MODE_NEGATIVE:
                begin
                    if (acc_next[VALUE_WIDTH-1] && (acc_next[VALUE_WIDTH-2:0] != '0))
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        result_w = '0 - acc_next;
                    end
                end
                default:
                begin
                    result_w = acc_next;
                end
            endcase
        end
        result_ext = OUT_W'(result_w);
        value_next = result_ext[31:0];
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
            mode_reg     <= MODE_SIGNED;
            acc_reg      <= '0;
            flags_reg    <= '0;
        end
        else if (s1_consume)
        begin
            at_start_reg <= s1_last_reg;
            mode_reg     <= mode_next;
            acc_reg      <= acc_next;
            flags_reg    <= flags_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= ST_NUMBER;
            value_reg     <= '0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_consume && s1_last_reg;
            if (s1_consume && s1_last_reg)
            begin
                status_reg <= status_next;
                value_reg  <= value_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;

endmodule

/* sv/ntr_char_step.sv */
// one character of a token applied to the running parse state
module ntr_char_step
    import ntr_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic [7:0]             token_char,
    input  logic                   at_start,
    input  mode_t                  mode_in,
    input  logic [VALUE_WIDTH-1:0] acc_in,
    input  ntr_flags_t             flags_in,
    output mode_t                  mode_out,
    output logic [VALUE_WIDTH-1:0] acc_out,
    output ntr_flags_t             flags_out
);

    localparam int SUM_W = VALUE_WIDTH + 5;

    mode_t                  mode_base;
    logic [VALUE_WIDTH-1:0] acc_base;
    ntr_flags_t             flags_base;
    logic                   body;
    logic [DIGIT_W-1:0]     digit;
    logic [DIGIT_W-1:0]     base;
    logic [SUM_W-1:0]       prod;
    logic [SUM_W-1:0]       sum;

    // token start: clear progress and pick the mode from a prefix character
    always_comb
    begin
        mode_base  = mode_in;
        acc_base   = acc_in;
        flags_base = flags_in;
        body       = 1'b1;
        if (at_start)
        begin
            acc_base   = '0;
            flags_base = '0;
            mode_base  = MODE_SIGNED;
            case (token_char)
                CHAR_DOLLAR:
                begin
                    mode_base = MODE_HEX;
                    body      = 1'b0;
                end
                CHAR_MINUS:
                begin
                    mode_base = MODE_NEGATIVE;
                    body      = 1'b0;
                end
                CHAR_PLUS:
                begin
                    mode_base = MODE_UNSIGNED;
                    body      = 1'b0;
                end
                default:
                begin
                    body = 1'b1;
                end
            endcase
        end
    end

    // acc * base + digit, wide enough to see any carry past the value width
    always_comb
    begin
        digit = digit_value(token_char);
        base  = (mode_base == MODE_HEX) ? BASE_HEX : BASE_DEC;
        if (mode_base == MODE_HEX)
        begin
            prod = SUM_W'({acc_base, 4'b0000});
        end
        else
        begin
            prod = SUM_W'({acc_base, 3'b000}) + SUM_W'({acc_base, 1'b0});
        end
        sum = prod + SUM_W'(digit);
    end

    // accumulate, first fault wins
    always_comb
    begin
        mode_out  = mode_base;
        acc_out   = acc_base;
        flags_out = flags_base;
        if (body)
        begin
            flags_out.seen_digit = 1'b1;
            if (!flags_base.bad_digit && !flags_base.overflow)
            begin
                if (digit >= base)
                begin
                    flags_out.bad_digit = 1'b1;
                end
                else if (sum[SUM_W-1:VALUE_WIDTH] != '0)
                begin
                    flags_out.overflow = 1'b1;
                end
                else
                begin
                    acc_out = sum[VALUE_WIDTH-1:0];
                end
            end
        end
    end

endmodule
